// ----- src/h2d_pkg.sv -----
// shared constants, types and helpers of the two-dimensional histogram core
// no dependencies; used by every other file of the block but h2d_ram
package h2d_pkg;

  localparam int MAX_BINS_PER_AXIS = 64;
  localparam int COUNT_WIDTH       = 32;

  localparam int BIN_W       = $clog2(MAX_BINS_PER_AXIS);
  localparam int ADDR_W      = 2 * BIN_W;
  localparam int STORE_DEPTH = MAX_BINS_PER_AXIS * MAX_BINS_PER_AXIS;
  localparam int VAL_W       = 32;
  localparam int PROD_W      = VAL_W + BIN_W;
  localparam int STEP_W      = (BIN_W > 1) ? $clog2(BIN_W) : 1;
  localparam int OUT_W       = 32;
  localparam int READ_BIN_W  = 12;
  localparam int KIND_W      = 2;
  localparam int CFG_BINS_W  = 7;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_X_BINS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_BINS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_X_LOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_X_HIGH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_LOW  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_HIGH = 3'd5;

  typedef struct packed {
    logic                    start;
    logic signed [VAL_W-1:0] value;
    logic signed [VAL_W-1:0] low;
    logic signed [VAL_W-1:0] high;
    logic [BIN_W-1:0]        bins_m1;
  } axis_req_t;

  typedef struct packed {
    logic             done;
    logic [BIN_W-1:0] bin;
  } axis_rsp_t;

  // bin count in use: zero acts as one, clipped to the store size
  function automatic logic [BIN_W:0] eff_bins(input logic [CFG_BINS_W-1:0] n);
    logic [BIN_W:0] r;
    if (n == '0) begin
      r = (BIN_W+1)'(1);
    end else if (int'(n) > MAX_BINS_PER_AXIS) begin
      r = (BIN_W+1)'(MAX_BINS_PER_AXIS);
    end else begin
      r = (BIN_W+1)'(n);
    end
    return r;
  endfunction

endpackage

// ----- src/h2d_if.sv -----
// valid/ready channel interfaces of the histogram core: samples, counts, config
// depends on h2d_pkg for field widths
interface h2d_sample_if;
  logic                              valid;
  logic                              ready;
  logic [h2d_pkg::KIND_W-1:0]        kind;
  logic signed [h2d_pkg::VAL_W-1:0]  x_value;
  logic signed [h2d_pkg::VAL_W-1:0]  y_value;
  logic [h2d_pkg::READ_BIN_W-1:0]    read_bin;
  modport source (output valid, kind, x_value, y_value, read_bin, input ready);
  modport sink   (input valid, kind, x_value, y_value, read_bin, output ready);
endinterface

interface h2d_count_if;
  logic                       valid;
  logic                       ready;
  logic [h2d_pkg::OUT_W-1:0]  bin_count;
  modport source (output valid, bin_count, input ready);
  modport sink   (input valid, bin_count, output ready);
endinterface

interface h2d_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [h2d_pkg::CFG_IDX_W-1:0]   index;
  logic [h2d_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/h2d_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
module h2d_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/h2d_axis_div.sv -----
// one axis binning unit: bit-serial multiply by (bins-1), then bit-serial divide by span
// depends on h2d_pkg
module h2d_axis_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  h2d_pkg::axis_req_t req_i,
  output h2d_pkg::axis_rsp_t rsp_o
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_MUL  = 2'd1;
  localparam logic [1:0] PH_DIV  = 2'd2;

  localparam logic [h2d_pkg::STEP_W-1:0] STEP_LAST = h2d_pkg::STEP_W'(h2d_pkg::BIN_W - 1);

  logic [1:0]                    phase_q, phase_d;
  logic [h2d_pkg::STEP_W-1:0]    step_q, step_d;
  logic                          done_q, done_d;
  logic [h2d_pkg::VAL_W-1:0]     span_q, span_d;
  logic [h2d_pkg::VAL_W-1:0]     diff_q, diff_d;
  logic [h2d_pkg::BIN_W-1:0]     mult_q, mult_d;
  logic [h2d_pkg::PROD_W-1:0]    acc_q, acc_d;
  logic [h2d_pkg::PROD_W-1:0]    dv_q, dv_d;
  logic [h2d_pkg::BIN_W-1:0]     quo_q, quo_d;

  logic signed [h2d_pkg::VAL_W:0] span_full;
  logic signed [h2d_pkg::VAL_W:0] diff_full;
  logic                           below;
  logic                           above;
  logic                           qbit;

  assign span_full = {req_i.high[h2d_pkg::VAL_W-1], req_i.high}
                   - {req_i.low[h2d_pkg::VAL_W-1], req_i.low};
  assign diff_full = {req_i.value[h2d_pkg::VAL_W-1], req_i.value}
                   - {req_i.low[h2d_pkg::VAL_W-1], req_i.low};
  assign below = ($signed(req_i.high) <= $signed(req_i.low))
              || ($signed(req_i.value) <= $signed(req_i.low));
  assign above = $signed(req_i.value) >= $signed(req_i.high);

  always_comb begin
    phase_d = phase_q;
    step_d  = step_q;
    done_d  = done_q;
    span_d  = span_q;
    diff_d  = diff_q;
    mult_d  = mult_q;
    acc_d   = acc_q;
    dv_d    = dv_q;
    quo_d   = quo_q;
    qbit    = 1'b0;
    unique case (phase_q)
      PH_IDLE: begin
        if (req_i.start) begin
          done_d = 1'b0;
          if (below) begin
            quo_d  = '0;
            done_d = 1'b1;
          end else if (above) begin
            quo_d  = req_i.bins_m1;
            done_d = 1'b1;
          end else begin
            span_d  = h2d_pkg::VAL_W'(span_full);
            diff_d  = h2d_pkg::VAL_W'(diff_full);
            mult_d  = req_i.bins_m1;
            acc_d   = '0;
            step_d  = STEP_LAST;
            phase_d = PH_MUL;
          end
        end
      end
      PH_MUL: begin
        // msb-first shift and add, one multiplier bit a cycle
        acc_d  = {acc_q[h2d_pkg::PROD_W-2:0], 1'b0}
               + (mult_q[h2d_pkg::BIN_W-1] ? h2d_pkg::PROD_W'(diff_q) : '0);
        mult_d = h2d_pkg::BIN_W'({mult_q, 1'b0});
        step_d = step_q - 1'b1;
        if (step_q == '0) begin
          phase_d = PH_DIV;
          step_d  = STEP_LAST;
          dv_d    = h2d_pkg::PROD_W'(span_q) << (h2d_pkg::BIN_W - 1);
        end
      end
      PH_DIV: begin
        // restoring division, one quotient bit a cycle; quotient never exceeds bins-1
        if (acc_q >= dv_q) begin
          acc_d = acc_q - dv_q;
          qbit  = 1'b1;
        end
        quo_d  = h2d_pkg::BIN_W'({quo_q, qbit});
        dv_d   = dv_q >> 1;
        step_d = step_q - 1'b1;
        if (step_q == '0) begin
          phase_d = PH_IDLE;
          done_d  = 1'b1;
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      step_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      step_q  <= step_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    span_q <= span_d;
    diff_q <= diff_d;
    mult_q <= mult_d;
    acc_q  <= acc_d;
    dv_q   <= dv_d;
    quo_q  <= quo_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.bin  = quo_q;

endmodule

// ----- src/histogram_2d_binning_core.sv -----
// Two-dimensional histogram core. After reset, and after every clear transaction, the
// core sweeps the whole count store once, one entry per cycle, and takes no sample
// transaction meanwhile; config writes are always taken. In an add transaction both
// axis units run in parallel, each doing a bit-serial multiply by (bins-1) and then a
// bit-serial divide by the range span; values at or outside the range finish at once.
// Then comes a read-modify-write of the counter. A read transaction goes through the
// store's registered read port. The count answer sits in an output register, so the
// next transaction is taken while it waits.
// Depends on h2d_pkg, h2d_if, h2d_ram and h2d_axis_div.
module histogram_2d_binning_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  h2d_sample_if.sink   sample_i,
  h2d_count_if.source  count_o,
  h2d_cfg_if.sink      cfg_i
);

  localparam logic [3:0] ST_CLEAR     = 4'd0;
  localparam logic [3:0] ST_IDLE      = 4'd1;
  localparam logic [3:0] ST_AXIS_GO   = 4'd2;
  localparam logic [3:0] ST_AXIS_WAIT = 4'd3;
  localparam logic [3:0] ST_INDEX     = 4'd4;
  localparam logic [3:0] ST_RMW_RD    = 4'd5;
  localparam logic [3:0] ST_RMW_WR    = 4'd6;
  localparam logic [3:0] ST_RD        = 4'd7;
  localparam logic [3:0] ST_RD_OUT    = 4'd8;

  localparam logic [h2d_pkg::ADDR_W-1:0] ADDR_LAST =
    h2d_pkg::ADDR_W'(h2d_pkg::STORE_DEPTH - 1);

  logic [3:0]                       state_q, state_d;
  logic [h2d_pkg::ADDR_W-1:0]       addr_q, addr_d;
  logic                             rd_zero_q, rd_zero_d;
  logic signed [h2d_pkg::VAL_W-1:0] x_q, x_d;
  logic signed [h2d_pkg::VAL_W-1:0] y_q, y_d;
  logic                             out_valid_q, out_valid_d;
  logic [h2d_pkg::OUT_W-1:0]        out_data_q, out_data_d;

  logic [h2d_pkg::CFG_BINS_W-1:0]   x_bins_q, y_bins_q;
  logic signed [h2d_pkg::VAL_W-1:0] x_low_q, x_high_q, y_low_q, y_high_q;

  logic [h2d_pkg::BIN_W:0]          nx, ny;
  logic [h2d_pkg::ADDR_W-1:0]       idx;

  h2d_pkg::axis_req_t               x_req, y_req;
  h2d_pkg::axis_rsp_t               x_rsp, y_rsp;

  logic                             ram_we, ram_re;
  logic [h2d_pkg::ADDR_W-1:0]       ram_waddr, ram_raddr;
  logic [h2d_pkg::COUNT_WIDTH-1:0]  ram_wdata, ram_rdata;

  // config registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_bins_q <= h2d_pkg::CFG_BINS_W'(8);
      y_bins_q <= h2d_pkg::CFG_BINS_W'(8);
      x_low_q  <= '0;
      x_high_q <= '0;
      y_low_q  <= '0;
      y_high_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        h2d_pkg::CFG_X_BINS: x_bins_q <= cfg_i.data[h2d_pkg::CFG_BINS_W-1:0];
        h2d_pkg::CFG_Y_BINS: y_bins_q <= cfg_i.data[h2d_pkg::CFG_BINS_W-1:0];
        h2d_pkg::CFG_X_LOW:  x_low_q  <= $signed(cfg_i.data[h2d_pkg::VAL_W-1:0]);
        h2d_pkg::CFG_X_HIGH: x_high_q <= $signed(cfg_i.data[h2d_pkg::VAL_W-1:0]);
        h2d_pkg::CFG_Y_LOW:  y_low_q  <= $signed(cfg_i.data[h2d_pkg::VAL_W-1:0]);
        h2d_pkg::CFG_Y_HIGH: y_high_q <= $signed(cfg_i.data[h2d_pkg::VAL_W-1:0]);
        default: ;
      endcase
    end
  end

  assign nx = h2d_pkg::eff_bins(x_bins_q);
  assign ny = h2d_pkg::eff_bins(y_bins_q);

  // axis units
  assign x_req.start   = (state_q == ST_AXIS_GO);
  assign x_req.value   = x_q;
  assign x_req.low     = x_low_q;
  assign x_req.high    = x_high_q;
  assign x_req.bins_m1 = h2d_pkg::BIN_W'(nx - 1'b1);
  assign y_req.start   = (state_q == ST_AXIS_GO);
  assign y_req.value   = y_q;
  assign y_req.low     = y_low_q;
  assign y_req.high    = y_high_q;
  assign y_req.bins_m1 = h2d_pkg::BIN_W'(ny - 1'b1);

  h2d_axis_div u_x_axis (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (x_req),
    .rsp_o  (x_rsp)
  );

  h2d_axis_div u_y_axis (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (y_req),
    .rsp_o  (y_rsp)
  );

  // row-major bin index
  assign idx = h2d_pkg::ADDR_W'(h2d_pkg::ADDR_W'(y_rsp.bin) * h2d_pkg::ADDR_W'(nx)
                              + h2d_pkg::ADDR_W'(x_rsp.bin));

  h2d_ram #(
    .WIDTH (h2d_pkg::COUNT_WIDTH),
    .DEPTH (h2d_pkg::STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign sample_i.ready  = (state_q == ST_IDLE);
  assign count_o.valid     = out_valid_q;
  assign count_o.bin_count = out_data_q;

  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    rd_zero_d   = rd_zero_q;
    x_d         = x_q;
    y_d         = y_q;
    out_valid_d = out_valid_q && !count_o.ready;
    out_data_d  = out_data_q;
    ram_we      = 1'b0;
    ram_waddr   = addr_q;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = addr_q;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we = 1'b1;
        addr_d = addr_q + 1'b1;
        if (addr_q == ADDR_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (sample_i.valid) begin
          unique case (sample_i.kind)
            h2d_pkg::KIND_ADD: begin
              x_d     = sample_i.x_value;
              y_d     = sample_i.y_value;
              state_d = ST_AXIS_GO;
            end
            h2d_pkg::KIND_READ: begin
              addr_d    = h2d_pkg::ADDR_W'(sample_i.read_bin);
              rd_zero_d = int'(sample_i.read_bin) >= h2d_pkg::STORE_DEPTH;
              state_d   = ST_RD;
            end
            h2d_pkg::KIND_CLEAR: begin
              addr_d  = '0;
              state_d = ST_CLEAR;
            end
            default: ;
          endcase
        end
      end
      ST_AXIS_GO: begin
        state_d = ST_AXIS_WAIT;
      end
      ST_AXIS_WAIT: begin
        if (x_rsp.done && y_rsp.done) begin
          state_d = ST_INDEX;
        end
      end
      ST_INDEX: begin
        addr_d  = idx;
        state_d = ST_RMW_RD;
      end
      ST_RMW_RD: begin
        ram_re  = 1'b1;
        state_d = ST_RMW_WR;
      end
      ST_RMW_WR: begin
        // saturating increment
        ram_we    = 1'b1;
        ram_wdata = (ram_rdata == h2d_pkg::COUNT_MAX) ? ram_rdata : ram_rdata + 1'b1;
        state_d   = ST_IDLE;
      end
      ST_RD: begin
        ram_re  = 1'b1;
        state_d = ST_RD_OUT;
      end
      ST_RD_OUT: begin
        // store read data holds until the output register frees up
        if (!out_valid_q || count_o.ready) begin
          out_valid_d = 1'b1;
          out_data_d  = rd_zero_q ? '0 : h2d_pkg::OUT_W'(ram_rdata);
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      addr_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_zero_q  <= rd_zero_d;
    x_q        <= x_d;
    y_q        <= y_d;
    out_data_q <= out_data_d;
  end

  // axis results always land inside the configured grid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INDEX) |-> ((h2d_pkg::BIN_W+1)'(x_rsp.bin) < nx))
    else $error("x bin outside the configured bin count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INDEX) |-> ((h2d_pkg::BIN_W+1)'(y_rsp.bin) < ny))
    else $error("y bin outside the configured bin count");

  // a counter update never wraps around
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RMW_WR) |-> (ram_wdata >= ram_rdata))
    else $error("bin counter wrapped");

  // a count answer only comes out of a read transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_RD_OUT))
    else $error("count answer without a read");

endmodule

// ----- test/testbench.sv -----
// self-checking bench for histogram_2d_binning_core: drives samples and register writes,
// mirrors the bin store and compares every bin count read back against it
// depends on h2d_pkg, the h2d_if channel interfaces and the core
module testbench;

  localparam logic [h2d_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int VAL_MIN         = 32'sh8000_0000;
  localparam int VAL_MAX         = 32'sh7fff_ffff;
  localparam int SETTLE_CYCLES   = 64;
  localparam int HOLD_OFF_CYCLES = 400;
  // a store sweep after reset or clear is quiet
  localparam int STALL_LIMIT     = 20000;
  localparam int PHASES          = 12;
  localparam int PHASE_ITEMS     = 150;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    logic [h2d_pkg::CFG_BINS_W-1:0]   x_bins;
    logic [h2d_pkg::CFG_BINS_W-1:0]   y_bins;
    logic signed [h2d_pkg::VAL_W-1:0] x_low;
    logic signed [h2d_pkg::VAL_W-1:0] x_high;
    logic signed [h2d_pkg::VAL_W-1:0] y_low;
    logic signed [h2d_pkg::VAL_W-1:0] y_high;
  } binning_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  h2d_sample_if sample_ch ();
  h2d_count_if  count_ch ();
  h2d_cfg_if    cfg_ch ();

  histogram_2d_binning_core DUT (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .sample_i(sample_ch),
    .count_o (count_ch),
    .cfg_i   (cfg_ch)
  );

  logic [h2d_pkg::COUNT_WIDTH-1:0] tally [h2d_pkg::STORE_DEPTH];
  logic [h2d_pkg::OUT_W-1:0]       pending_counts [$];
  binning_t                        model_cfg;
  binning_t                        stim_cfg;
  int                              fail_count = 0;
  int                              quiet_cycles = 0;
  int                              send_idle_pct = 0;
  int                              recv_stall_pct = 0;
  logic                            hold_off_req = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic binning_t make_settings(input int unsigned xb, yb,
                                             input int xl, xh, yl, yh);
    binning_t s;
    s.x_bins = h2d_pkg::CFG_BINS_W'(xb);
    s.y_bins = h2d_pkg::CFG_BINS_W'(yb);
    s.x_low  = xl;
    s.x_high = xh;
    s.y_low  = yl;
    s.y_high = yh;
    return s;
  endfunction

  // zero bins behaves as one, anything past the store edge as the maximum
  function automatic int unsigned bins_in_use(input logic [h2d_pkg::CFG_BINS_W-1:0] n);
    if (n == '0) return 1;
    if (n > h2d_pkg::MAX_BINS_PER_AXIS) return h2d_pkg::MAX_BINS_PER_AXIS;
    return n;
  endfunction

  function automatic int unsigned axis_slot(input logic signed [h2d_pkg::VAL_W-1:0] v,
                                            lo, hi, input int unsigned n);
    longint span;
    longint diff;
    if (hi <= lo || v <= lo) return 0;
    if (v >= hi) return n - 1;
    span = longint'(hi) - longint'(lo);
    diff = longint'(v) - longint'(lo);
    return int'((longint'(n - 1) * diff) / span);
  endfunction

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $time, msg);
  endfunction

  // mirror of the core's store and registers
  always @(posedge clk) begin
    int unsigned nx;
    int unsigned slot;
    if (!rst_n) begin
      foreach (tally[i]) tally[i] = '0;
      model_cfg = make_settings(8, 8, 0, 0, 0, 0);
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          h2d_pkg::CFG_X_BINS: model_cfg.x_bins = cfg_ch.data[h2d_pkg::CFG_BINS_W-1:0];
          h2d_pkg::CFG_Y_BINS: model_cfg.y_bins = cfg_ch.data[h2d_pkg::CFG_BINS_W-1:0];
          h2d_pkg::CFG_X_LOW:  model_cfg.x_low  = cfg_ch.data;
          h2d_pkg::CFG_X_HIGH: model_cfg.x_high = cfg_ch.data;
          h2d_pkg::CFG_Y_LOW:  model_cfg.y_low  = cfg_ch.data;
          h2d_pkg::CFG_Y_HIGH: model_cfg.y_high = cfg_ch.data;
          default: ;
        endcase
      end
      if (sample_ch.valid && sample_ch.ready) begin
        case (sample_ch.kind)
          h2d_pkg::KIND_ADD: begin
            nx = bins_in_use(model_cfg.x_bins);
            slot = axis_slot(sample_ch.x_value, model_cfg.x_low, model_cfg.x_high, nx)
                 + axis_slot(sample_ch.y_value, model_cfg.y_low, model_cfg.y_high,
                             bins_in_use(model_cfg.y_bins)) * nx;
            if (tally[slot] != h2d_pkg::COUNT_MAX) tally[slot] = tally[slot] + 1'b1;
          end
          h2d_pkg::KIND_READ: pending_counts.push_back(tally[sample_ch.read_bin]);
          h2d_pkg::KIND_CLEAR: begin
            foreach (tally[i]) tally[i] = '0;
          end
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    logic [h2d_pkg::OUT_W-1:0] want;
    if (rst_n && count_ch.valid && count_ch.ready) begin
      if (pending_counts.size() == 0) begin
        note_failure($sformatf("bin_count %0d arrived with no read pending",
                               count_ch.bin_count));
      end else begin
        want = pending_counts.pop_front();
        if (count_ch.bin_count !== want) begin
          note_failure($sformatf("bin_count expected %0d, got %0d", want,
                                 count_ch.bin_count));
        end
      end
    end
  end

  // count side: random stalls plus an occasional long hold-off
  initial begin
    int   stall_left;
    logic seen_req;
    stall_left = 0;
    seen_req = 1'b0;
    count_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req != seen_req) begin
        seen_req = hold_off_req;
        stall_left = HOLD_OFF_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        count_ch.ready <= 1'b0;
      end else begin
        count_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((sample_ch.valid && sample_ch.ready) || (count_ch.valid && count_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // valid stays high across back-to-back transactions
  task automatic offer_item(input logic [h2d_pkg::KIND_W-1:0] kind,
                            input logic signed [h2d_pkg::VAL_W-1:0] x_val, y_val,
                            input logic [h2d_pkg::READ_BIN_W-1:0] bin_idx);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid    <= 1'b1;
    sample_ch.kind     <= kind;
    sample_ch.x_value  <= x_val;
    sample_ch.y_value  <= y_val;
    sample_ch.read_bin <= bin_idx;
    do @(posedge clk); while (!(sample_ch.valid && sample_ch.ready));
  endtask

  task automatic wait_for_counts();
    sample_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_counts.size() != 0);
  endtask

  task automatic write_reg(input logic [h2d_pkg::CFG_IDX_W-1:0] idx,
                           input logic [h2d_pkg::CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
  endtask

  // registers change only once the core has gone quiet
  task automatic apply_settings(input binning_t s);
    logic [h2d_pkg::CFG_DATA_W-1:0] noise;
    wait_for_counts();
    repeat (SETTLE_CYCLES) @(posedge clk);
    // a store sweep may still be running
    while (!sample_ch.ready) @(posedge clk);
    noise = $urandom;
    write_reg(h2d_pkg::CFG_X_BINS, {noise[h2d_pkg::CFG_DATA_W-1:h2d_pkg::CFG_BINS_W],
                                    s.x_bins});
    noise = $urandom;
    write_reg(h2d_pkg::CFG_Y_BINS, {noise[h2d_pkg::CFG_DATA_W-1:h2d_pkg::CFG_BINS_W],
                                    s.y_bins});
    write_reg(h2d_pkg::CFG_X_LOW, s.x_low);
    write_reg(h2d_pkg::CFG_X_HIGH, s.x_high);
    write_reg(h2d_pkg::CFG_Y_LOW, s.y_low);
    write_reg(h2d_pkg::CFG_Y_HIGH, s.y_high);
    cfg_ch.valid <= 1'b0;
    stim_cfg = s;
  endtask

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct = 0;
        recv_stall_pct <= 0;
      end
      IDLE_SENDER: begin
        send_idle_pct = 78;
        recv_stall_pct <= 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;
        recv_stall_pct <= 78;
      end
      default: begin
        send_idle_pct = 14;
        recv_stall_pct <= 14;
      end
    endcase
  endtask

  // mostly inside the range, with edges, outliers and raw noise mixed in
  function automatic logic signed [h2d_pkg::VAL_W-1:0] pick_value(
      input logic signed [h2d_pkg::VAL_W-1:0] lo, hi);
    longint      span;
    int unsigned sel;
    span = longint'(hi) - longint'(lo);
    sel = $urandom_range(99);
    if (sel < 8) return lo - $urandom_range(1, 64);
    if (sel < 16) return hi + $urandom_range(1, 64);
    if (sel < 22) return lo;
    if (sel < 28) return hi;
    if (sel < 40 || span <= 0) return $urandom;
    return h2d_pkg::VAL_W'(longint'(lo) + longint'($urandom) % (span + 1));
  endfunction

  function automatic logic [h2d_pkg::READ_BIN_W-1:0] pick_bin();
    int unsigned used;
    used = bins_in_use(stim_cfg.x_bins) * bins_in_use(stim_cfg.y_bins);
    if ($urandom_range(3) != 0) return h2d_pkg::READ_BIN_W'($urandom_range(used - 1));
    return h2d_pkg::READ_BIN_W'($urandom);
  endfunction

  function automatic logic [h2d_pkg::CFG_BINS_W-1:0] rand_bins();
    case ($urandom_range(7))
      0: return '0;
      1: return h2d_pkg::CFG_BINS_W'($urandom_range(h2d_pkg::MAX_BINS_PER_AXIS + 1, 127));
      default: return h2d_pkg::CFG_BINS_W'($urandom_range(1, h2d_pkg::MAX_BINS_PER_AXIS));
    endcase
  endfunction

  // wraparound may invert the range, which is a case worth having
  function automatic logic signed [h2d_pkg::VAL_W-1:0] rand_high(
      input logic signed [h2d_pkg::VAL_W-1:0] lo);
    case ($urandom_range(4))
      0: return lo + $urandom_range(1, 2000);
      1: return lo + $urandom_range(1, 1 << 24);
      2: return lo;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_reset_state();
    // reset values: every sample falls into bin 0 of an empty range
    set_idling(IDLE_NONE);
    stim_cfg = make_settings(8, 8, 0, 0, 0, 0);
    repeat (3) offer_item(h2d_pkg::KIND_ADD, $urandom, $urandom,
                          h2d_pkg::READ_BIN_W'($urandom));
    offer_item(h2d_pkg::KIND_READ, 0, 0, '0);
    offer_item(h2d_pkg::KIND_READ, 0, 0, h2d_pkg::READ_BIN_W'(1));
    offer_item(h2d_pkg::KIND_READ, '1, '1, '1);
  endtask

  task automatic test_edges();
    int unsigned probes [6] = '{0, 19, 16, 9, 14, 4095};
    apply_settings(make_settings(4, 5, -100, 100, 0, 1000));
    offer_item(h2d_pkg::KIND_ADD, VAL_MIN, VAL_MIN, '0);
    offer_item(h2d_pkg::KIND_ADD, -100, 0, '0);
    offer_item(h2d_pkg::KIND_ADD, 100, 1000, '0);
    offer_item(h2d_pkg::KIND_ADD, VAL_MAX, VAL_MAX, '1);
    offer_item(h2d_pkg::KIND_ADD, -101, 1001, '0);
    offer_item(h2d_pkg::KIND_ADD, 0, 500, '0);
    offer_item(h2d_pkg::KIND_ADD, 99, 999, '0);
    offer_item(KIND_UNUSED, '1, '1, '1);
    foreach (probes[i]) offer_item(h2d_pkg::KIND_READ, 0, 0,
                                   h2d_pkg::READ_BIN_W'(probes[i]));
    offer_item(h2d_pkg::KIND_CLEAR, '1, '1, '1);
    offer_item(h2d_pkg::KIND_READ, 0, 0, h2d_pkg::READ_BIN_W'(0));
    offer_item(h2d_pkg::KIND_READ, 0, 0, h2d_pkg::READ_BIN_W'(19));
    offer_item(h2d_pkg::KIND_ADD, 50, 250, '0);
    offer_item(h2d_pkg::KIND_READ, 0, 0, h2d_pkg::READ_BIN_W'(6));
  endtask

  task automatic test_backpressure();
    set_idling(IDLE_NONE);
    hold_off_req <= ~hold_off_req;
    // count side holds off while reads keep coming, so the input must stall
    repeat (40) begin
      if ($urandom_range(3) == 0) begin
        offer_item(h2d_pkg::KIND_ADD, pick_value(stim_cfg.x_low, stim_cfg.x_high),
                   pick_value(stim_cfg.y_low, stim_cfg.y_high),
                   h2d_pkg::READ_BIN_W'($urandom));
      end else begin
        offer_item(h2d_pkg::KIND_READ, $urandom, $urandom, pick_bin());
      end
    end
    // sample side goes silent until every count is back
    wait_for_counts();
    repeat (6) offer_item(h2d_pkg::KIND_READ, $urandom, $urandom, pick_bin());
  endtask

  task automatic test_random_phases();
    binning_t    s;
    int unsigned sel;
    int unsigned counted;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: s = make_settings(8, 8, -1000, 1000, -1000, 1000);
        1: s = make_settings(64, 64, VAL_MIN, VAL_MAX, VAL_MIN, VAL_MAX);
        2: s = make_settings(1, 1, 0, 100, 0, 100);
        3: s = make_settings(0, 127, -50, 50, 10, 20);
        4: s = make_settings(65, 3, 5, 5, 100, -100);
        5: s = make_settings(2, 64, VAL_MAX, VAL_MIN, -7, 7);
        6: s = make_settings(64, 1, -5, VAL_MAX, VAL_MIN, 0);
        default: begin
          s.x_bins = rand_bins();
          s.y_bins = rand_bins();
          s.x_low  = $urandom;
          s.x_high = rand_high(s.x_low);
          s.y_low  = $urandom;
          s.y_high = rand_high(s.y_low);
        end
      endcase
      set_idling(idle_mode_e'(p % 4));
      apply_settings(s);
      // without a clear, counts from the old binning stay in the store
      if ($urandom_range(1) == 1) offer_item(h2d_pkg::KIND_CLEAR, $urandom, $urandom, '0);
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        sel = $urandom_range(99);
        if (sel < 60) begin
          offer_item(h2d_pkg::KIND_ADD, pick_value(stim_cfg.x_low, stim_cfg.x_high),
                     pick_value(stim_cfg.y_low, stim_cfg.y_high),
                     h2d_pkg::READ_BIN_W'($urandom));
        end else if (sel < 93) begin
          offer_item(h2d_pkg::KIND_READ, $urandom, $urandom, pick_bin());
        end else if (sel < 99) begin
          offer_item(KIND_UNUSED, $urandom, $urandom, h2d_pkg::READ_BIN_W'($urandom));
        end else begin
          offer_item(h2d_pkg::KIND_CLEAR, $urandom, $urandom,
                     h2d_pkg::READ_BIN_W'($urandom));
        end
        counted++;
      end
    end
  endtask

  initial begin
    sample_ch.valid    = 1'b0;
    sample_ch.kind     = h2d_pkg::KIND_ADD;
    sample_ch.x_value  = '0;
    sample_ch.y_value  = '0;
    sample_ch.read_bin = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = h2d_pkg::CFG_X_BINS;
    cfg_ch.data        = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_edges();
    test_backpressure();
    test_random_phases();
    wait_for_counts();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_counts.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
